>>> design/bsse_pkg.sv
// ----------------------------------------------------------------------------
// Binary to seven-segment encoder package
// Shared widths, register indexes, status codes and the segment font.
// ----------------------------------------------------------------------------
package bsse_pkg;

	localparam int VALUE_W    = 16;
	localparam int BCD_DIGITS = 5;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int SEG_W      = 8;
	localparam int OUT_DIGITS = 4;
	localparam int CELLS      = VALUE_W;

	localparam logic [SEG_W-1:0] SEG_INVALID = 8'h40;
	localparam logic [SEG_W-1:0] SEG_POINT   = 8'h80;
	localparam logic [SEG_W-1:0] SEG_BLANK   = 8'h00;

	typedef enum logic [1:0] {
		REG_DIGIT_COUNT    = 2'd0,
		REG_POINT_ENABLE   = 2'd1,
		REG_POINT_POSITION = 2'd2,
		REG_REVERSE_ORDER  = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_POINT = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0] digit_count;
		logic       point_enable;
		logic [1:0] point_position;
		logic       reverse_order;
	} cfg_t;

	typedef struct packed {
		logic [BCD_W-1:0]   bcd;
		logic [VALUE_W-1:0] bin;
	} dd_word_t;

	function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] digit);
		logic [SEG_W-1:0] pattern;
		case (digit)
			4'd0: pattern = 8'h3F;
			4'd1: pattern = 8'h06;
			4'd2: pattern = 8'h5B;
			4'd3: pattern = 8'h4F;
			4'd4: pattern = 8'h66;
			4'd5: pattern = 8'h6D;
			4'd6: pattern = 8'h7D;
			4'd7: pattern = 8'h07;
			4'd8: pattern = 8'h7F;
			4'd9: pattern = 8'h6F;
			default: pattern = SEG_INVALID;
		endcase
		return pattern;
	endfunction

endpackage

>>> design/bsse_dd_cell.sv
// ----------------------------------------------------------------------------
// Double dabble cell
// One add-3 and shift step: every BCD digit of five or more gets three added,
// then the top binary bit is shifted into the BCD field. Output registered.
// ----------------------------------------------------------------------------
module bsse_dd_cell
	import bsse_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     valid_i,
	input  dd_word_t word_i,
	output logic     valid_o,
	output dd_word_t word_o
);

	logic             valid_q;
	dd_word_t         word_q;
	logic [BCD_W-1:0] adj;

	always_comb begin
		for (int d = 0; d < BCD_DIGITS; d++) begin
			if (word_i.bcd[4*d +: 4] >= 4'd5) begin
				adj[4*d +: 4] = word_i.bcd[4*d +: 4] + 4'd3;
			end else begin
				adj[4*d +: 4] = word_i.bcd[4*d +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		word_q.bcd <= {adj[BCD_W-2:0], word_i.bin[VALUE_W-1]};
		word_q.bin <= {word_i.bin[VALUE_W-2:0], 1'b0};
	end

	assign valid_o = valid_q;
	assign word_o  = word_q;

endmodule

>>> design/bsse_seg_fmt.sv
// ----------------------------------------------------------------------------
// Segment formatter
// Range check, font lookup, decimal point, digit reversal and status.
// Output registered with a one-cycle done strobe.
// ----------------------------------------------------------------------------
module bsse_seg_fmt
	import bsse_pkg::*;
#(
	parameter int MAX_DIGITS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            valid_i,
	input  logic [BCD_W-1:0]                bcd_i,
	input  cfg_t                            cfg_i,
	output logic                            done_o,
	output logic [OUT_DIGITS-1:0][SEG_W-1:0] seg_o,
	output status_t                         status_o
);

	logic [2:0]                       n;
	logic                             over;
	logic [OUT_DIGITS-1:0][SEG_W-1:0] seg_raw;
	logic [OUT_DIGITS-1:0][SEG_W-1:0] seg_rev;
	logic [2:0]                       rev_idx;
	status_t                          status_c;
	logic                             done_q;
	logic [OUT_DIGITS-1:0][SEG_W-1:0] seg_q;
	status_t                          status_q;

	always_comb begin
		if (cfg_i.digit_count < 3'd2) begin
			n = 3'd2;
		end else if (cfg_i.digit_count > 3'(MAX_DIGITS)) begin
			n = 3'(MAX_DIGITS);
		end else begin
			n = cfg_i.digit_count;
		end
	end

	always_comb begin
		over = 1'b0;
		for (int d = 0; d < BCD_DIGITS; d++) begin
			if ((3'(d) >= n) && (bcd_i[4*d +: 4] != 4'd0)) begin
				over = 1'b1;
			end
		end
	end

	always_comb begin
		status_c = over ? ST_RANGE : ST_OK;
		for (int i = 0; i < OUT_DIGITS; i++) begin
			if (3'(i) >= n) begin
				seg_raw[i] = SEG_BLANK;
			end else if (over) begin
				seg_raw[i] = SEG_INVALID;
			end else begin
				seg_raw[i] = seg_font(bcd_i[4*i +: 4]);
			end
		end
		if (cfg_i.point_enable) begin
			if ({1'b0, cfg_i.point_position} < n) begin
				seg_raw[cfg_i.point_position] = seg_raw[cfg_i.point_position] | SEG_POINT;
			end else if (!over) begin
				status_c = ST_POINT;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < OUT_DIGITS; i++) begin
			rev_idx = 3'(n - 3'd1 - 3'(i));
			if (3'(i) >= n) begin
				seg_rev[i] = SEG_BLANK;
			end else if (cfg_i.reverse_order) begin
				seg_rev[i] = seg_raw[rev_idx[1:0]];
			end else begin
				seg_rev[i] = seg_raw[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_i) begin
			seg_q    <= seg_rev;
			status_q <= status_c;
		end
	end

	assign done_o   = done_q;
	assign seg_o    = seg_q;
	assign status_o = status_q;

endmodule

>>> design/binary_to_seven_segment_encoder_core.sv
// ----------------------------------------------------------------------------
// Binary to seven-segment encoder core
// Converts a 16-bit value to 2..4 decimal digits with a chain of double
// dabble cells and drives one seven-segment pattern per digit.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+--------------------------------
//   command  | in        | start, busy           | value
//   result   | out       | done (strobe)         | seg_digit0..seg_digit3, status
//   config   | in        | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
// A new value is taken every clock cycle while busy is low; each beat passes
// 16 cells, one bit per cell, and then the formatter register. Busy is high
// for the first cycle after reset and low after that. Configuration is read
// by the formatter stage, so the user must write it only while no beat is in
// flight; the block does not enforce it. The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module binary_to_seven_segment_encoder_core
	import bsse_pkg::*;
#(
	parameter int MAX_DIGITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] value,
	output logic        done,
	output logic [7:0]  seg_digit0,
	output logic [7:0]  seg_digit1,
	output logic [7:0]  seg_digit2,
	output logic [7:0]  seg_digit3,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data
);

	localparam int LATENCY = CELLS + 1;

	logic                             busy_q;
	cfg_t                             cfg_q;
	logic                             accept;
	logic [CELLS:0]                   valid_c;
	dd_word_t                         word_c [CELLS+1];
	logic [OUT_DIGITS-1:0][SEG_W-1:0] seg;
	status_t                          status_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.digit_count    <= 3'd4;
			cfg_q.point_enable   <= 1'b0;
			cfg_q.point_position <= 2'd0;
			cfg_q.reverse_order  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_DIGIT_COUNT:    cfg_q.digit_count    <= cfg_data;
				REG_POINT_ENABLE:   cfg_q.point_enable   <= cfg_data[0];
				REG_POINT_POSITION: cfg_q.point_position <= cfg_data[1:0];
				REG_REVERSE_ORDER:  cfg_q.reverse_order  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign busy      = busy_q;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy_q;

	assign valid_c[0]    = accept;
	assign word_c[0].bcd = '0;
	assign word_c[0].bin = value;

	for (genvar c = 0; c < CELLS; c++) begin : g_cell
		bsse_dd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (valid_c[c]),
			.word_i  (word_c[c]),
			.valid_o (valid_c[c+1]),
			.word_o  (word_c[c+1])
		);
	end

	bsse_seg_fmt #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_fmt (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_i  (valid_c[CELLS]),
		.bcd_i    (word_c[CELLS].bcd),
		.cfg_i    (cfg_q),
		.done_o   (done),
		.seg_o    (seg),
		.status_o (status_c)
	);

	assign seg_digit0 = seg[0];
	assign seg_digit1 = seg[1];
	assign seg_digit2 = seg[2];
	assign seg_digit3 = seg[3];
	assign status     = status_c;

	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("accepted beat did not produce a result");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without an accepted beat");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_RANGE || status == ST_POINT))
		else $error("illegal status code");

	a_unused_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cfg_q.digit_count <= 3'd2) |-> (seg_digit2 == SEG_BLANK
			&& seg_digit3 == SEG_BLANK))
		else $error("unused digit positions not blank");

endmodule

>>> tb/sv/binary_to_seven_segment_encoder_core_test.sv
// ----------------------------------------------------------------------------
// Binary to seven-segment encoder core testbench
// Drives values through the command port under a series of display settings
// and checks every result beat against a mirror of the digit encoding, the
// range and point rules and the digit reversal.
// ----------------------------------------------------------------------------
module binary_to_seven_segment_encoder_core_test;
	import bsse_pkg::*;

	localparam int NUM_DIGITS  = 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 75;

	typedef struct packed {
		logic [3:0][7:0] seg;
		status_t         st;
	} display_t;

	class display_scoreboard;
		cfg_t       cfg;
		logic [7:0] glyph [10];
		display_t   pending_displays [$];
		int         errors;

		function new();
			cfg = '{digit_count: 3'd4, point_enable: 1'b0, point_position: 2'd0,
				reverse_order: 1'b0};
			glyph = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F,
				8'h6F};
			errors = 0;
		endfunction

		function void write_reg(reg_index_t idx, logic [2:0] data);
			case (idx)
				REG_DIGIT_COUNT: cfg.digit_count = data;
				REG_POINT_ENABLE: cfg.point_enable = data[0];
				REG_POINT_POSITION: cfg.point_position = data[1:0];
				REG_REVERSE_ORDER: cfg.reverse_order = data[0];
				default: ;
			endcase
		endfunction

		function int used_digits();
			int n;
			n = int'(cfg.digit_count);
			if (n < 2) n = 2;
			if (n > NUM_DIGITS) n = NUM_DIGITS;
			return n;
		endfunction

		function int limit();
			int n;
			n = used_digits();
			return (n == 2) ? 99 : (n == 3) ? 999 : 9999;
		endfunction

		function display_t encode_display(logic [15:0] v);
			display_t        d;
			logic [3:0][7:0] tmp;
			int              n;
			int              rest;
			n = used_digits();
			d.seg = '0;
			d.st = ST_OK;
			if (int'(v) > limit()) begin
				for (int i = 0; i < n; i++) d.seg[i] = SEG_INVALID;
				d.st = ST_RANGE;
			end else begin
				rest = int'(v);
				for (int i = 0; i < n; i++) begin
					d.seg[i] = glyph[rest % 10];
					rest = rest / 10;
				end
			end
			if (cfg.point_enable) begin
				if (int'(cfg.point_position) < n) begin
					d.seg[cfg.point_position] = d.seg[cfg.point_position] | SEG_POINT;
				end else if (d.st == ST_OK) begin
					d.st = ST_POINT;
				end
			end
			if (cfg.reverse_order) begin
				tmp = d.seg;
				for (int i = 0; i < n; i++) d.seg[i] = tmp[n - 1 - i];
			end
			return d;
		endfunction

		function void note_value(logic [15:0] v);
			pending_displays.push_back(encode_display(v));
		endfunction

		function void check_display(logic [3:0][7:0] seg, logic [1:0] st);
			display_t exp;
			if (pending_displays.size() == 0) begin
				$error("result beat with no expected display pending");
				errors++;
				return;
			end
			exp = pending_displays.pop_front();
			for (int i = 0; i < NUM_DIGITS; i++) begin
				if (seg[i] !== exp.seg[i]) begin
					$error("seg_digit%0d expected %h got %h", i, exp.seg[i], seg[i]);
					errors++;
				end
			end
			if (st !== exp.st) begin
				$error("status expected %0d got %0d", exp.st, st);
				errors++;
			end
		endfunction

		function int pending();
			return pending_displays.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] value;
	logic        done;
	logic [7:0]  seg_digit0;
	logic [7:0]  seg_digit1;
	logic [7:0]  seg_digit2;
	logic [7:0]  seg_digit3;
	logic [1:0]  status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [2:0]  cfg_data;

	display_scoreboard displays = new();
	int                cycles = 0;
	bit                steady = 0;

	binary_to_seven_segment_encoder_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.done       (done),
		.seg_digit0 (seg_digit0),
		.seg_digit1 (seg_digit1),
		.seg_digit2 (seg_digit2),
		.seg_digit3 (seg_digit3),
		.status     (status),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (cfg_valid && cfg_ready) displays.write_reg(reg_index_t'(cfg_index), cfg_data);
			if (start && !busy) displays.note_value(value);
			if (done) begin
				displays.check_display({seg_digit3, seg_digit2, seg_digit1, seg_digit0},
					status);
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("binary_to_seven_segment_encoder_core verification failed");
				$finish;
			end
		end
	end

	function automatic int draw_gap();
		if (steady) return 0;
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
	endfunction

	task automatic send_value(input logic [15:0] v);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			value <= 16'($urandom_range(0, 65535));
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (displays.pending() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [2:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_display(input logic [2:0] count, input logic [2:0] pe,
		input logic [2:0] pos, input logic [2:0] rev);
		drain_results();
		write_reg(REG_DIGIT_COUNT, count);
		write_reg(REG_POINT_ENABLE, pe);
		write_reg(REG_POINT_POSITION, pos);
		write_reg(REG_REVERSE_ORDER, rev);
	endtask

	function automatic logic [15:0] pick_value(int lim);
		case ($urandom_range(0, 7))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'(lim - 1 + $urandom_range(0, 2));
			2: return 16'($urandom_range(0, 99));
			default: return 16'($urandom_range(0, lim));
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_display(3'd4, 3'd0, 3'd0, 3'd0);
		send_value(16'd0);
		send_value(16'd9);
		send_value(16'd10);
		send_value(16'd1234);
		send_value(16'd9999);
		send_value(16'd10000);
		send_value(16'd65535);

		// Count below two saturates, and a point beyond the digits flags status.
		set_display(3'd1, 3'd1, 3'd3, 3'd1);
		send_value(16'd0);
		send_value(16'd42);
		send_value(16'd99);
		send_value(16'd100);

		set_display(3'd3, 3'd1, 3'd2, 3'd1);
		send_value(16'd5);
		send_value(16'd999);
		send_value(16'd1000);

		set_display(3'd7, 3'd1, 3'd3, 3'd0);
		send_value(16'd8765);
		send_value(16'hAAAA);
		send_value(16'h5555);
		send_value(16'd65535);

		set_display(3'd2, 3'd0, 3'd3, 3'd1);
		send_value(16'd57);
		send_value(16'd3);

		for (int p = 0; p < PHASES; p++) begin
			set_display((p == 0) ? 3'd0 : (p == 1) ? 3'd7 : 3'($urandom_range(0, 7)),
				3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
				3'($urandom_range(0, 7)));
			steady = (p % 3 == 2);
			for (int k = 0; k < PHASE_ITEMS; k++) send_value(pick_value(displays.limit()));
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (displays.pending() != 0) begin
			$error("%0d expected displays never arrived", displays.pending());
			displays.errors++;
		end
		if (displays.errors == 0) begin
			$display("binary_to_seven_segment_encoder_core verification clean");
		end else begin
			$display("binary_to_seven_segment_encoder_core verification failed");
		end
		$finish;
	end

endmodule
